// ===== design/ffpa_pkg.sv =====
package ffpa_pkg;

   // Defaults for the pool geometry.
   localparam int DEF_POOL_BYTES   = 32768;
   localparam int DEF_ALIGN_BYTES  = 8;
   localparam int DEF_HEADER_BYTES = 24;

   // Fixed field widths of the request and response beats.
   localparam int FUNC_W = 2;
   localparam int ADDR_W = 15;
   localparam int REQ_W  = 16;
   localparam int STAT_W = 2;
   localparam int COPY_W = 16;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REALLOC = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOSPACE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD      = 2'd3;

   typedef logic [FUNC_W-1:0] func_type;

endpackage

// ===== design/first_fit_pool_allocator.sv =====
// First-fit pool allocator. After reset the block sweeps its header store once,
// one granule per cycle (POOL_BYTES / ALIGN_BYTES granules, 4096 by default), and
// holds busy high meanwhile. An operation is taken when start is high and busy
// is low; its single response beat appears on the rsp_ ports for one cycle with
// rsp_valid high and cannot be stalled, so capture it when it comes. The time
// per operation is set by the header store's one read port, which the sequencer
// walks one header at a time, and by one shared reciprocal multiplier that turns
// a byte count into granules. A free of null or an unused operation answers in
// the next cycle without raising busy. An allocate sizes the request through
// the multiplier, then visits the blocks one header at a time; on a split it
// writes the new free header and then its own. A free checks the address, marks
// the block free, then walks the whole chain from the start, reading each header
// and the next, and reads again after each merge. A reallocate checks the
// address and sizes the request, keeps the block in place if it fits or can grow
// into a free neighbor, frees it for size zero, and else runs an allocate walk
// and, if that finds space, a free walk. The response beat comes in the first
// cycle with busy low again; the worst case grows with the number of blocks in the chain.
module first_fit_pool_allocator #(
   parameter int POOL_BYTES   = ffpa_pkg::DEF_POOL_BYTES,
   parameter int ALIGN_BYTES  = ffpa_pkg::DEF_ALIGN_BYTES,
   parameter int HEADER_BYTES = ffpa_pkg::DEF_HEADER_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  ffpa_pkg::func_type            req_func,
   input  logic                          req_has_address,
   input  logic [ffpa_pkg::ADDR_W-1:0]   req_address,
   input  logic [ffpa_pkg::REQ_W-1:0]    req_request_size,
   output logic                          rsp_valid,
   output logic [ffpa_pkg::STAT_W-1:0]   rsp_status,
   output logic [ffpa_pkg::ADDR_W-1:0]   rsp_result_address,
   output logic                          rsp_moved,
   output logic [ffpa_pkg::COPY_W-1:0]   rsp_copy_bytes
);
   import ffpa_pkg::*;

   // Geometry derived from the parameters.
   localparam int HDR    = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam int HDR_G  = HDR / ALIGN_BYTES;
   localparam int NGRAN  = POOL_BYTES / ALIGN_BYTES;
   localparam int GW     = $clog2(NGRAN);
   localparam int SW     = $clog2(POOL_BYTES + 1);
   localparam int SGW    = $clog2(NGRAN + 1);
   localparam int NW     = $clog2(POOL_BYTES) + 2;
   localparam int DVW    = REQ_W + 1;
   localparam int RW     = $clog2(ALIGN_BYTES) + 1;
   localparam int CW     = (SW > DVW + RW ? SW : DVW + RW) + 2;
   localparam int INIT_SZ  = POOL_BYTES - HDR;
   localparam int INIT_SZG = (POOL_BYTES - HDR) / ALIGN_BYTES;

   // Reciprocal of ALIGN_BYTES, exact for every DVW-bit dividend.
   localparam int RSH    = DVW + $clog2(ALIGN_BYTES);
   localparam int RECIP  = ((1 << RSH) + ALIGN_BYTES - 1) / ALIGN_BYTES;
   localparam int MW     = DVW + RSH + 1;

   // Sequencer state codes.
   localparam int STW = 4;
   localparam logic [STW-1:0] S_CLEAR  = 4'd0;
   localparam logic [STW-1:0] S_IDLE   = 4'd1;
   localparam logic [STW-1:0] S_DIV    = 4'd2;
   localparam logic [STW-1:0] S_CHKA   = 4'd3;
   localparam logic [STW-1:0] S_CHK    = 4'd4;
   localparam logic [STW-1:0] S_SIZE   = 4'd5;
   localparam logic [STW-1:0] S_RA_CMP = 4'd6;
   localparam logic [STW-1:0] S_RA_NXT = 4'd7;
   localparam logic [STW-1:0] S_RA_MZ  = 4'd8;
   localparam logic [STW-1:0] S_AL_CHK = 4'd9;
   localparam logic [STW-1:0] S_AL_SPL = 4'd10;
   localparam logic [STW-1:0] S_FR_SET = 4'd11;
   localparam logic [STW-1:0] S_FR_C1  = 4'd12;
   localparam logic [STW-1:0] S_FR_C2  = 4'd13;
   localparam logic [STW-1:0] S_FR_Z   = 4'd14;

   // One header: start mark, free mark, payload bytes and payload granules.
   typedef struct packed {
      logic           start;
      logic           free;
      logic [SW-1:0]  size;
      logic [SGW-1:0] sizeg;
   } entry_type;

   // Header store.
   entry_type hdr_mem [NGRAN];
   entry_type rdata_ff;
   logic [GW-1:0] raddr;
   logic          we;
   logic [GW-1:0] waddr;
   entry_type     wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         hdr_mem[waddr] <= wdata;
      end
      rdata_ff <= hdr_mem[raddr];
   end

   // Control and work registers.
   logic [STW-1:0]   state_ff, state_in;
   logic [GW-1:0]    clr_ff, clr_in;
   func_type         func_ff, func_in;
   logic             alloc_ff, alloc_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [REQ_W-1:0] req_ff, req_in;
   logic             dsel_ff, dsel_in;
   logic [DVW-1:0]   dq_ff, dq_in;
   logic [CW-1:0]    size_ff, size_in;
   logic [DVW-1:0]   sizeg_ff, sizeg_in;
   logic [GW-1:0]    pg_ff, pg_in;
   logic [NW-1:0]    ppos_ff, ppos_in;
   entry_type        old_ff, old_in;
   logic [GW-1:0]    cur_ff, cur_in;
   logic [NW-1:0]    pos_ff, pos_in;
   entry_type        cw_ff, cw_in;
   logic [GW-1:0]    ng_ff, ng_in;
   logic [NW-1:0]    npos_ff, npos_in;
   logic [NW-1:0]    newpos_ff, newpos_in;

   // Set in the cycle after a merge so the absorbed header gets cleared.
   logic             merge_pend_ff;

   // Response beat registers.
   logic              vld_ff;
   logic [STAT_W-1:0] stat_ff;
   logic [ADDR_W-1:0] radr_ff;
   logic              mov_ff;
   logic [COPY_W-1:0] copy_ff;

   logic              fin;
   logic [STAT_W-1:0] fin_status;
   logic [ADDR_W-1:0] fin_addr;
   logic              fin_moved;
   logic [COPY_W-1:0] fin_copy;

   // Shared reciprocal multiplier: divides the work value by ALIGN_BYTES.
   logic [MW-1:0]  div_prod;
   logic [DVW-1:0] div_q;

   always_comb begin
      div_prod = MW'(dq_ff) * MW'(RECIP);
      div_q    = DVW'(div_prod >> RSH);
   end

   // Chain arithmetic on the word just read.
   logic [NW-1:0] n_bytes;
   logic [GW-1:0] n_gran;
   logic [CW-1:0] w_size;
   logic [CW-1:0] merge_sum;

   always_comb begin
      w_size    = CW'(rdata_ff.size);
      n_bytes   = pos_ff + NW'(HDR) + NW'(rdata_ff.size);
      n_gran    = GW'(cur_ff + GW'(HDR_G) + GW'(rdata_ff.sizeg));
      merge_sum = CW'(cw_ff.size) + CW'(HDR) + w_size;
   end

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      func_in   = func_ff;
      alloc_in  = alloc_ff;
      addr_in   = addr_ff;
      req_in    = req_ff;
      dsel_in   = dsel_ff;
      dq_in     = dq_ff;
      size_in   = size_ff;
      sizeg_in  = sizeg_ff;
      pg_in     = pg_ff;
      ppos_in   = ppos_ff;
      old_in    = old_ff;
      cur_in    = cur_ff;
      pos_in    = pos_ff;
      cw_in     = cw_ff;
      ng_in     = ng_ff;
      npos_in   = npos_ff;
      newpos_in = newpos_ff;
      raddr     = cur_ff;
      we        = 1'b0;
      waddr     = cur_ff;
      wdata     = '0;
      fin        = 1'b0;
      fin_status = ST_BAD;
      fin_addr   = '0;
      fin_moved  = 1'b0;
      fin_copy   = '0;

      case (state_ff)
         S_CLEAR: begin
            // Sweep the store; granule zero gets the one free block.
            we    = 1'b1;
            waddr = clr_ff;
            if (clr_ff == '0) begin
               wdata = '{start: 1'b1, free: 1'b1, size: SW'(INIT_SZ), sizeg: SGW'(INIT_SZG)};
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == GW'(NGRAN - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               func_in  = req_func;
               addr_in  = req_address;
               req_in   = req_request_size;
               alloc_in = (req_func == FUNC_ALLOC) ||
                          (req_func == FUNC_REALLOC && !req_has_address);
               if (req_func == FUNC_ALLOC ||
                   (req_func == FUNC_REALLOC && !req_has_address)) begin
                  dq_in    = DVW'(req_request_size) + DVW'(ALIGN_BYTES - 1);
                  dsel_in  = 1'b1;
                  state_in = S_DIV;
               end else if (req_func == FUNC_FREE && !req_has_address) begin
                  fin        = 1'b1;
                  fin_status = ST_RELEASED;
               end else if (req_func == FUNC_FREE || req_func == FUNC_REALLOC) begin
                  if (NW'(req_address) < NW'(HDR)) begin
                     fin        = 1'b1;
                     fin_status = ST_BAD;
                  end else begin
                     dq_in    = DVW'(NW'(req_address) - NW'(HDR));
                     dsel_in  = 1'b0;
                     state_in = S_DIV;
                  end
               end else begin
                  fin        = 1'b1;
                  fin_status = ST_BAD;
               end
            end
         end

         S_DIV: begin
            // Byte count to granules in one pass through the multiplier.
            dq_in    = div_q;
            state_in = dsel_ff ? S_SIZE : S_CHKA;
         end

         S_CHKA: begin
            // Address must sit on a granule inside the pool.
            if ((CW'(dq_ff) * CW'(ALIGN_BYTES)) != CW'(NW'(addr_ff) - NW'(HDR)) ||
                (DVW+1)'(dq_ff) >= (DVW+1)'(NGRAN)) begin
               fin        = 1'b1;
               fin_status = ST_BAD;
               state_in   = S_IDLE;
            end else begin
               raddr    = GW'(dq_ff);
               pg_in    = GW'(dq_ff);
               ppos_in  = NW'(addr_ff) - NW'(HDR);
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            if (!rdata_ff.start || rdata_ff.free) begin
               fin        = 1'b1;
               fin_status = ST_BAD;
               state_in   = S_IDLE;
            end else begin
               old_in = rdata_ff;
               if (func_ff == FUNC_FREE || req_ff == '0) begin
                  state_in = S_FR_SET;
               end else begin
                  dq_in    = DVW'(req_ff) + DVW'(ALIGN_BYTES - 1);
                  dsel_in  = 1'b1;
                  state_in = S_DIV;
               end
            end
         end

         S_SIZE: begin
            sizeg_in = dq_ff;
            size_in  = CW'(CW'(dq_ff) * CW'(ALIGN_BYTES));
            if (alloc_ff) begin
               cur_in   = '0;
               pos_in   = '0;
               raddr    = '0;
               state_in = S_AL_CHK;
            end else begin
               state_in = S_RA_CMP;
            end
         end

         S_RA_CMP: begin
            ng_in = GW'(pg_ff + GW'(HDR_G) + GW'(old_ff.sizeg));
            if (CW'(old_ff.size) >= size_ff) begin
               fin        = 1'b1;
               fin_status = ST_OK;
               fin_addr   = addr_ff;
               state_in   = S_IDLE;
            end else if (ppos_ff + NW'(HDR) + NW'(old_ff.size) >= NW'(POOL_BYTES)) begin
               cur_in   = '0;
               pos_in   = '0;
               raddr    = '0;
               state_in = S_AL_CHK;
            end else begin
               raddr    = GW'(pg_ff + GW'(HDR_G) + GW'(old_ff.sizeg));
               state_in = S_RA_NXT;
            end
         end

         S_RA_NXT: begin
            // Grow into a free next block when the pair is big enough.
            if (rdata_ff.free &&
                CW'(old_ff.size) + CW'(HDR) + w_size >= size_ff) begin
               we       = 1'b1;
               waddr    = pg_ff;
               wdata    = '{start: 1'b1, free: 1'b0,
                            size: SW'(CW'(old_ff.size) + CW'(HDR) + w_size),
                            sizeg: SGW'(old_ff.sizeg + SGW'(HDR_G) + rdata_ff.sizeg)};
               state_in = S_RA_MZ;
            end else begin
               cur_in   = '0;
               pos_in   = '0;
               raddr    = '0;
               state_in = S_AL_CHK;
            end
         end

         S_RA_MZ: begin
            we         = 1'b1;
            waddr      = ng_ff;
            fin        = 1'b1;
            fin_status = ST_OK;
            fin_addr   = addr_ff;
            state_in   = S_IDLE;
         end

         S_AL_CHK: begin
            // First-fit walk: one header per cycle.
            if (rdata_ff.free && w_size >= size_ff) begin
               if (w_size > size_ff + CW'(HDR)) begin
                  we       = 1'b1;
                  waddr    = GW'(cur_ff + GW'(HDR_G) + GW'(sizeg_ff));
                  wdata    = '{start: 1'b1, free: 1'b1,
                               size: SW'(w_size - size_ff - CW'(HDR)),
                               sizeg: SGW'(rdata_ff.sizeg - SGW'(sizeg_ff) - SGW'(HDR_G))};
                  state_in = S_AL_SPL;
               end else begin
                  we    = 1'b1;
                  waddr = cur_ff;
                  wdata = '{start: 1'b1, free: 1'b0, size: rdata_ff.size,
                            sizeg: rdata_ff.sizeg};
                  if (alloc_ff) begin
                     fin        = 1'b1;
                     fin_status = ST_OK;
                     fin_addr   = ADDR_W'(pos_ff + NW'(HDR));
                     state_in   = S_IDLE;
                  end else begin
                     newpos_in = pos_ff;
                     state_in  = S_FR_SET;
                  end
               end
            end else if (n_bytes >= NW'(POOL_BYTES)) begin
               fin        = 1'b1;
               fin_status = ST_NOSPACE;
               state_in   = S_IDLE;
            end else begin
               cur_in = n_gran;
               pos_in = n_bytes;
               raddr  = n_gran;
            end
         end

         S_AL_SPL: begin
            we    = 1'b1;
            waddr = cur_ff;
            wdata = '{start: 1'b1, free: 1'b0, size: SW'(size_ff), sizeg: SGW'(sizeg_ff)};
            if (alloc_ff) begin
               fin        = 1'b1;
               fin_status = ST_OK;
               fin_addr   = ADDR_W'(pos_ff + NW'(HDR));
               state_in   = S_IDLE;
            end else begin
               newpos_in = pos_ff;
               state_in  = S_FR_SET;
            end
         end

         S_FR_SET: begin
            // Mark the block free, then walk the chain from the start.
            we       = 1'b1;
            waddr    = pg_ff;
            wdata    = '{start: 1'b1, free: 1'b1, size: old_ff.size, sizeg: old_ff.sizeg};
            cur_in   = '0;
            pos_in   = '0;
            state_in = S_FR_Z;
         end

         S_FR_Z: begin
            // Read the current header again; after a merge the absorbed one is cleared below.
            raddr    = cur_ff;
            state_in = S_FR_C1;
         end

         S_FR_C1: begin
            if (n_bytes >= NW'(POOL_BYTES)) begin
               fin = 1'b1;
               if (func_ff == FUNC_REALLOC && req_ff != '0) begin
                  fin_status = ST_OK;
                  fin_addr   = ADDR_W'(newpos_ff + NW'(HDR));
                  fin_moved  = 1'b1;
                  fin_copy   = COPY_W'(old_ff.size);
               end else begin
                  fin_status = ST_RELEASED;
               end
               state_in = S_IDLE;
            end else begin
               cw_in    = rdata_ff;
               ng_in    = n_gran;
               npos_in  = n_bytes;
               raddr    = n_gran;
               state_in = S_FR_C2;
            end
         end

         S_FR_C2: begin
            if (cw_ff.free && rdata_ff.free) begin
               we       = 1'b1;
               waddr    = cur_ff;
               wdata    = '{start: 1'b1, free: 1'b1, size: SW'(merge_sum),
                            sizeg: SGW'(cw_ff.sizeg + SGW'(HDR_G) + rdata_ff.sizeg)};
               state_in = S_FR_Z;
            end else begin
               cur_in   = ng_ff;
               pos_in   = npos_ff;
               raddr    = ng_ff;
               state_in = S_FR_C1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Zero the absorbed header in the cycle after a merge.
      if (state_ff == S_FR_Z && merge_pend_ff) begin
         we    = 1'b1;
         waddr = ng_ff;
         wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_pend_ff <= 1'b0;
      end else begin
         merge_pend_ff <= (state_ff == S_FR_C2) && cw_ff.free && rdata_ff.free;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         vld_ff   <= fin;
      end
   end

   // Work and response payload registers.
   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      alloc_ff  <= alloc_in;
      addr_ff   <= addr_in;
      req_ff    <= req_in;
      dsel_ff   <= dsel_in;
      dq_ff     <= dq_in;
      size_ff   <= size_in;
      sizeg_ff  <= sizeg_in;
      pg_ff     <= pg_in;
      ppos_ff   <= ppos_in;
      old_ff    <= old_in;
      cur_ff    <= cur_in;
      pos_ff    <= pos_in;
      cw_ff     <= cw_in;
      ng_ff     <= ng_in;
      npos_ff   <= npos_in;
      newpos_ff <= newpos_in;
      if (fin) begin
         stat_ff <= fin_status;
         radr_ff <= fin_addr;
         mov_ff  <= fin_moved;
         copy_ff <= fin_copy;
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = vld_ff;
   assign rsp_status         = stat_ff;
   assign rsp_result_address = radr_ff;
   assign rsp_moved          = mov_ff;
   assign rsp_copy_bytes     = copy_ff;

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ffpa_pkg::*;

   // Pool geometry as the block is built by default.
   localparam int POOL  = DEF_POOL_BYTES;
   localparam int ALIGN = DEF_ALIGN_BYTES;
   localparam int HDR   = ((DEF_HEADER_BYTES + ALIGN - 1) / ALIGN) * ALIGN;
   localparam int NGRAN = POOL / ALIGN;
   localparam func_type FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ADDR_W-1:0] address;
      logic              moved;
      logic [COPY_W-1:0] copy_bytes;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   func_type            req_func = FUNC_ALLOC;
   logic                req_has_address = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [REQ_W-1:0]    req_request_size = '0;
   logic                rsp_valid;
   logic [STAT_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]   rsp_result_address;
   logic                rsp_moved;
   logic [COPY_W-1:0]   rsp_copy_bytes;

   first_fit_pool_allocator uut (.*);

   // Shadow copy of the header store.
   bit blk_start [NGRAN];
   bit blk_free  [NGRAN];
   int blk_size  [NGRAN];

   outcome_type pending_q [$];
   int       live_blocks [$];
   int       mismatches = 0;
   int       checked = 0;
   int       op_count [4];
   int       status_count [4];
   bit       checker_on = 1'b0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Generous limit on the whole run.
   initial begin
      #(12.0 * 6_000_000);
      $display("tb failed");
      $finish;
   end

   // Pool state right after reset: one free block spanning the whole pool.
   function automatic void model_reset();
      foreach (blk_start[i]) begin
         blk_start[i] = 1'b0;
         blk_free[i]  = 1'b0;
         blk_size[i]  = 0;
      end
      blk_start[0] = 1'b1;
      blk_free[0]  = 1'b1;
      blk_size[0]  = POOL - HDR;
   endfunction

   function automatic int align_up(int s);
      return ((s + ALIGN - 1) / ALIGN) * ALIGN;
   endfunction

   // Header offset of the block after pos, or POOL at the end of the chain.
   function automatic int chain_next(int pos);
      int n;
      n = pos + HDR + blk_size[pos / ALIGN];
      if (n >= POOL || (n % ALIGN) != 0 || !blk_start[n / ALIGN]) return POOL;
      return n;
   endfunction

   // Absorb the free block at n into the block at pos.
   function automatic void absorb(int pos, int n);
      blk_size[pos / ALIGN] += HDR + blk_size[n / ALIGN];
      blk_start[n / ALIGN] = 1'b0;
      blk_free[n / ALIGN]  = 1'b0;
      blk_size[n / ALIGN]  = 0;
   endfunction

   function automatic int first_fit(int req);
      int sz, pos, g, np;
      sz = align_up(req);
      pos = 0;
      while (pos < POOL) begin
         g = pos / ALIGN;
         if (blk_free[g] && blk_size[g] >= sz) begin
            if (blk_size[g] > sz + HDR) begin
               np = (pos + HDR + sz) / ALIGN;
               if (np < NGRAN) begin
                  blk_start[np] = 1'b1;
                  blk_free[np]  = 1'b1;
                  blk_size[np]  = blk_size[g] - sz - HDR;
                  blk_size[g]   = sz;
               end
            end
            blk_free[g] = 1'b0;
            return pos;
         end
         pos = chain_next(pos);
      end
      return POOL;
   endfunction

   // Release a block, then merge every adjacent free pair.
   function automatic void release_blk(int pos);
      int cur, n;
      cur = 0;
      blk_free[pos / ALIGN] = 1'b1;
      while (cur < POOL) begin
         n = chain_next(cur);
         if (blk_free[cur / ALIGN] && n < POOL && blk_free[n / ALIGN]) absorb(cur, n);
         else cur = n;
      end
   endfunction

   // Header offset of a live allocated block, or POOL if the address is bad.
   function automatic int live_header(int addr);
      int pos;
      if (addr < HDR) return POOL;
      pos = addr - HDR;
      if ((pos % ALIGN) != 0 || pos / ALIGN >= NGRAN) return POOL;
      if (!blk_start[pos / ALIGN] || blk_free[pos / ALIGN]) return POOL;
      return pos;
   endfunction

   function automatic outcome_type predict_outcome(func_type f, bit has, int addr, int req);
      outcome_type o;
      int p, q, g, n, sz;
      o = '{status: ST_BAD, address: '0, moved: 1'b0, copy_bytes: '0};
      if (f == FUNC_ALLOC || (f == FUNC_REALLOC && !has)) begin
         p = first_fit(req);
         if (p < POOL) begin
            o.status = ST_OK;
            o.address = ADDR_W'(p + HDR);
         end else o.status = ST_NOSPACE;
      end else if (f == FUNC_FREE) begin
         if (!has) o.status = ST_RELEASED;
         else begin
            p = live_header(addr);
            if (p < POOL) begin
               release_blk(p);
               o.status = ST_RELEASED;
            end
         end
      end else if (f == FUNC_REALLOC) begin
         p = live_header(addr);
         if (p < POOL) begin
            g = p / ALIGN;
            sz = align_up(req);
            n = chain_next(p);
            if (req == 0) begin
               release_blk(p);
               o.status = ST_RELEASED;
            end else if (blk_size[g] >= sz) begin
               o.status = ST_OK;
               o.address = ADDR_W'(addr);
            end else if (n < POOL && blk_free[n / ALIGN] &&
                         blk_size[g] + HDR + blk_size[n / ALIGN] >= sz) begin
               absorb(p, n);
               o.status = ST_OK;
               o.address = ADDR_W'(addr);
            end else begin
               q = first_fit(req);
               if (q < POOL) begin
                  o.copy_bytes = COPY_W'(blk_size[g]);
                  release_blk(p);
                  o.status = ST_OK;
                  o.address = ADDR_W'(q + HDR);
                  o.moved = 1'b1;
               end else o.status = ST_NOSPACE;
            end
         end
      end
      return o;
   endfunction

   // Keep the list of live payload addresses in step with the prediction.
   function automatic void track_blocks(func_type f, bit has, int addr, outcome_type o);
      int idx [$];
      bit drop;
      drop = (f == FUNC_FREE && o.status == ST_RELEASED && has) ||
             (f == FUNC_REALLOC && has && (o.status == ST_RELEASED || o.moved));
      if (drop) begin
         idx = live_blocks.find_first_index(x) with (x == addr);
         if (idx.size() > 0) live_blocks.delete(idx[0]);
      end
      if (o.status == ST_OK && (f == FUNC_ALLOC || !has || o.moved))
         live_blocks.push_back(o.address);
   endfunction

   // Send one command beat; returns its predicted outcome once accepted.
   task automatic send_cmd(func_type f, bit has, int addr, int req, output outcome_type o);
      @(negedge clock);
      start <= 1'b1;
      req_func <= f;
      req_has_address <= has;
      req_address <= addr[ADDR_W-1:0];
      req_request_size <= req[REQ_W-1:0];
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      o = predict_outcome(f, has, addr[ADDR_W-1:0], req[REQ_W-1:0]);
      pending_q.push_back(o);
      track_blocks(f, has, addr[ADDR_W-1:0], o);
      op_count[f]++;
      status_count[o.status]++;
   endtask

   task automatic idle_cycles(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_cycles(0);
      while (pending_q.size() != 0) @(negedge clock);
   endtask

   // Compare each response beat with the oldest prediction.
   always @(posedge clock) begin
      outcome_type got, want;
      if (checker_on && rsp_valid) begin
         got = '{rsp_status, rsp_result_address, rsp_moved, rsp_copy_bytes};
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat: %p", got);
         end else begin
            want = pending_q.pop_front();
            checked++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Hand-picked sequences covering every operation and each error path.
   task automatic test_directed();
      outcome_type o;
      int a, b;
      send_cmd(FUNC_ALLOC, 1'b0, 0, 0, o);
      send_cmd(FUNC_ALLOC, 1'b0, 0, 65535, o);
      send_cmd(FUNC_ALLOC, 1'b0, 0, 100, o);
      a = o.address;
      send_cmd(FUNC_ALLOC, 1'b0, 0, 40, o);
      b = o.address;
      send_cmd(FUNC_ALLOC, 1'b0, 0, 7, o);
      send_cmd(FUNC_FREE, 1'b1, b, 0, o);
      // Grow into the free neighbor, then shrink in place.
      send_cmd(FUNC_REALLOC, 1'b1, a, 150, o);
      send_cmd(FUNC_REALLOC, 1'b1, a, 16, o);
      // Grow past the neighbor so the block must move, then fail to move.
      send_cmd(FUNC_REALLOC, 1'b1, a, 4000, o);
      a = o.address;
      send_cmd(FUNC_REALLOC, 1'b1, a, 65535, o);
      send_cmd(FUNC_REALLOC, 1'b1, a, 0, o);
      send_cmd(FUNC_FREE, 1'b1, a, 0, o);
      send_cmd(FUNC_FREE, 1'b1, 3, 0, o);
      send_cmd(FUNC_FREE, 1'b1, HDR + 4, 0, o);
      send_cmd(FUNC_FREE, 1'b1, 32000, 0, o);
      send_cmd(FUNC_FREE, 1'b0, 0, 0, o);
      send_cmd(FUNC_REALLOC, 1'b0, 32767, 8, o);
      send_cmd(FUNC_REALLOC, 1'b1, 7, 8, o);
      send_cmd(FUNC_UNUSED, 1'b1, 32767, 65535, o);
      send_cmd(FUNC_ALLOC, 1'b0, 0, 32744, o);
      wait_drained();
   endtask

   function automatic int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return $urandom() & 16'hFFFF;
      if (r < 10) return $urandom_range(0, 4096);
      return $urandom_range(0, 400);
   endfunction

   // Mostly well-formed traffic on live blocks, with some noise mixed in.
   task automatic test_random(int items);
      outcome_type o;
      int sent, burst, r, addr;
      func_type f;
      bit has;
      sent = 0;
      while (sent < items) begin
         burst = $urandom_range(1, 20);
         while (burst > 0 && sent < items) begin
            r = $urandom_range(0, 99);
            has = 1'b1;
            addr = 0;
            if (live_blocks.size() > 80) r = 45 + r % 55;
            if (r < 40 || (r < 90 && live_blocks.size() == 0)) begin
               f = FUNC_ALLOC;
               has = 1'($urandom_range(0, 1));
               addr = $urandom();
            end else if (r < 90) begin
               f = (r < 65) ? FUNC_FREE : FUNC_REALLOC;
               addr = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            end else begin
               f = func_type'($urandom_range(1, 3));
               has = $urandom_range(0, 2) != 0;
               addr = $urandom();
            end
            send_cmd(f, has, addr, pick_size(), o);
            sent++;
            burst--;
         end
         if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 30));
         if ($urandom_range(0, 40) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      model_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      checker_on = 1'b1;
      test_directed();
      test_random(900);
      repeat (200) @(posedge clock);
      $display("covered %0d alloc, %0d free, %0d realloc, %0d unused-op commands",
               op_count[0], op_count[1], op_count[2], op_count[3]);
      $display("checked %0d responses: ok %0d, no space %0d, released %0d, bad %0d",
               checked, status_count[0], status_count[1], status_count[2], status_count[3]);
      if (mismatches == 0 && pending_q.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end
endmodule
